@@ rtl/tnrx_pkg.sv @@
package tnrx_pkg;

	localparam logic [7:0] B_IAC  = 8'd255;
	localparam logic [7:0] B_DONT = 8'd254;
	localparam logic [7:0] B_DO   = 8'd253;
	localparam logic [7:0] B_WONT = 8'd252;
	localparam logic [7:0] B_WILL = 8'd251;
	localparam logic [7:0] B_SB   = 8'd250;
	localparam logic [7:0] B_EL   = 8'd248;
	localparam logic [7:0] B_EC   = 8'd247;
	localparam logic [7:0] B_AYT  = 8'd246;
	localparam logic [7:0] B_IP   = 8'd244;
	localparam logic [7:0] B_BRK  = 8'd243;
	localparam logic [7:0] B_SE   = 8'd240;

	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_CR  = 8'h0d;
	localparam logic [7:0] CH_LF  = 8'h0a;
	localparam logic [7:0] CH_NUL = 8'h00;

	localparam logic [7:0] OPT_BIN  = 8'd0;
	localparam logic [7:0] OPT_ECHO = 8'd1;
	localparam logic [7:0] OPT_SGA  = 8'd3;

	// slots of the tracked options; every other option entry stays clear
	localparam int SLOT_BIN  = 0;
	localparam int SLOT_ECHO = 1;
	localparam int SLOT_SGA  = 2;
	localparam int NUM_SLOTS = 3;

	// mode flag bits
	localparam int F_ECHO = 0;
	localparam int F_CRLF = 1;
	localparam int F_RAW  = 2;

	localparam logic [2:0] FLAGS_RESET = 3'b011;
	localparam logic [NUM_SLOTS-1:0] OUR_RESET = 3'b010;

	localparam logic [1:0] CFG_ERASE = 2'd0;
	localparam logic [1:0] CFG_KILL  = 2'd1;
	localparam logic [1:0] CFG_INTR  = 2'd2;

	localparam logic [7:0] ERASE_RESET = 8'd8;
	localparam logic [7:0] KILL_RESET  = 8'd21;
	localparam logic [7:0] INTR_RESET  = 8'd127;

	localparam logic [1:0] BEAT_IAC  = 2'd0;
	localparam logic [1:0] BEAT_VERB = 2'd1;
	localparam logic [1:0] BEAT_OPT  = 2'd2;

	localparam int QUEUE_DEPTH_DEF = 2;

	// one queued action: a terminal byte, or a three-byte reply iac/verb/opt
	typedef struct packed {
		logic       is_reply;
		logic [7:0] val;
		logic [7:0] opt;
		logic [2:0] flags;
	} item_t;

endpackage

@@ rtl/tnrx_if.sv @@
interface tnrx_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;
	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

interface tnrx_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       to_network;
	logic       last;
	logic       echo_on;
	logic       crlf_map_on;
	logic       raw_on;
	modport source (output valid, output out_byte, output to_network, output last,
		output echo_on, output crlf_map_on, output raw_on, input ready);
	modport sink (input valid, input out_byte, input to_network, input last,
		input echo_on, input crlf_map_on, input raw_on, output ready);
endinterface

interface tnrx_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [7:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/tnrx_front.sv @@
module tnrx_front (
	input  logic            clk,
	input  logic            arst_n,
	tnrx_byte_if.sink       rx,
	tnrx_cfg_if.sink        cfg,
	input  logic            full,
	output logic            push,
	output tnrx_pkg::item_t push_item
);

	typedef enum logic [3:0] {
		ST_DATA, ST_CMD, ST_CR, ST_SUB, ST_SUBI, ST_WILL, ST_WONT, ST_DO, ST_DONT
	} state_t;

	state_t state_q, nxt_state;
	logic [tnrx_pkg::NUM_SLOTS-1:0] peer_q, our_q, nxt_peer, nxt_our;
	logic [2:0] flags_q, nxt_flags;
	logic [7:0] erase_q, kill_q, intr_q;

	logic [7:0] c;
	logic       accept, emit, tracked, do_data, peer_bit, our_bit;
	logic [1:0] slot;
	tnrx_pkg::item_t item;

	assign c      = rx.rx_byte;
	assign accept = rx.valid && !full;
	assign rx.ready  = !full;
	assign cfg.ready = 1'b1;

	assign tracked = (c == tnrx_pkg::OPT_BIN) || (c == tnrx_pkg::OPT_ECHO)
		|| (c == tnrx_pkg::OPT_SGA);

	always_comb begin
		if (c == tnrx_pkg::OPT_BIN) begin
			slot = 2'(tnrx_pkg::SLOT_BIN);
		end else if (c == tnrx_pkg::OPT_ECHO) begin
			slot = 2'(tnrx_pkg::SLOT_ECHO);
		end else begin
			slot = 2'(tnrx_pkg::SLOT_SGA);
		end
	end

	assign peer_bit = tracked && peer_q[slot];
	assign our_bit  = tracked && our_q[slot];
	assign do_data  = (state_q == ST_DATA)
		|| ((state_q == ST_CR) && (c != tnrx_pkg::CH_NUL) && (c != tnrx_pkg::CH_LF));

	always_comb begin
		nxt_state = ST_DATA;
		nxt_peer  = peer_q;
		nxt_our   = our_q;
		nxt_flags = flags_q;
		emit      = 1'b0;
		item.is_reply = 1'b0;
		item.val      = c;
		item.opt      = c;
		unique case (state_q)
			ST_DATA, ST_CR: begin
				if (do_data) begin
					if (c == tnrx_pkg::B_IAC) begin
						nxt_state = ST_CMD;
					end else begin
						emit = 1'b1;
						if (!our_q[tnrx_pkg::SLOT_BIN] && c == tnrx_pkg::CH_CR) begin
							nxt_state = ST_CR;
						end
					end
				end
			end
			ST_CMD: begin
				priority if (c == tnrx_pkg::B_IP || c == tnrx_pkg::B_BRK) begin
					emit = 1'b1;
					item.val = flags_q[tnrx_pkg::F_RAW] ? tnrx_pkg::CH_NUL : intr_q;
				end else if (c == tnrx_pkg::B_AYT) begin
					emit = 1'b1;
					item.val = tnrx_pkg::CH_BEL;
				end else if (c == tnrx_pkg::B_EC) begin
					emit = 1'b1;
					item.val = erase_q;
				end else if (c == tnrx_pkg::B_EL) begin
					emit = 1'b1;
					item.val = kill_q;
				end else if (c == tnrx_pkg::B_SB) begin
					nxt_state = ST_SUB;
				end else if (c == tnrx_pkg::B_WILL) begin
					nxt_state = ST_WILL;
				end else if (c == tnrx_pkg::B_WONT) begin
					nxt_state = ST_WONT;
				end else if (c == tnrx_pkg::B_DO) begin
					nxt_state = ST_DO;
				end else if (c == tnrx_pkg::B_DONT) begin
					nxt_state = ST_DONT;
				end else if (c == tnrx_pkg::B_IAC) begin
					emit = 1'b1;
				end else begin
					nxt_state = ST_DATA;
				end
			end
			ST_SUB: begin
				nxt_state = (c == tnrx_pkg::B_IAC) ? ST_SUBI : ST_SUB;
			end
			ST_SUBI: begin
				nxt_state = (c == tnrx_pkg::B_SE) ? ST_DATA : ST_SUB;
			end
			ST_WILL: begin
				if (!peer_bit) begin
					emit = 1'b1;
					item.is_reply = 1'b1;
					if (tracked) begin
						if (c == tnrx_pkg::OPT_BIN) begin
							nxt_flags[tnrx_pkg::F_RAW] = 1'b1;
						end else if (c == tnrx_pkg::OPT_ECHO) begin
							nxt_flags[tnrx_pkg::F_ECHO] = 1'b0;
							nxt_flags[tnrx_pkg::F_CRLF] = 1'b0;
						end
						nxt_peer[slot] = 1'b1;
						item.val = tnrx_pkg::B_DO;
					end else begin
						item.val = tnrx_pkg::B_DONT;
					end
				end
			end
			ST_WONT: begin
				if (peer_bit) begin
					emit = 1'b1;
					item.is_reply = 1'b1;
					item.val = tnrx_pkg::B_DONT;
					if (c == tnrx_pkg::OPT_ECHO) begin
						nxt_flags[tnrx_pkg::F_ECHO] = 1'b1;
						nxt_flags[tnrx_pkg::F_CRLF] = 1'b1;
					end else if (c == tnrx_pkg::OPT_BIN) begin
						nxt_flags[tnrx_pkg::F_RAW] = 1'b0;
					end
					nxt_peer[slot] = 1'b0;
				end
			end
			ST_DO: begin
				if (!our_bit) begin
					emit = 1'b1;
					item.is_reply = 1'b1;
					if (tracked) begin
						if (c == tnrx_pkg::OPT_ECHO) begin
							nxt_flags[tnrx_pkg::F_ECHO] = 1'b1;
							nxt_flags[tnrx_pkg::F_CRLF] = 1'b1;
						end else if (c == tnrx_pkg::OPT_BIN) begin
							nxt_flags[tnrx_pkg::F_RAW] = 1'b1;
						end
						nxt_our[slot] = 1'b1;
						item.val = tnrx_pkg::B_WILL;
					end else begin
						item.val = tnrx_pkg::B_WONT;
					end
				end
			end
			ST_DONT: begin
				if (our_bit) begin
					emit = 1'b1;
					item.is_reply = 1'b1;
					item.val = tnrx_pkg::B_WONT;
					nxt_our[slot] = 1'b0;
				end
			end
			default: begin
				nxt_state = ST_DATA;
			end
		endcase
		item.flags = nxt_flags;
	end

	assign push      = accept && emit;
	assign push_item = item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_DATA;
			peer_q  <= '0;
			our_q   <= tnrx_pkg::OUR_RESET;
			flags_q <= tnrx_pkg::FLAGS_RESET;
			erase_q <= tnrx_pkg::ERASE_RESET;
			kill_q  <= tnrx_pkg::KILL_RESET;
			intr_q  <= tnrx_pkg::INTR_RESET;
		end else begin
			if (accept) begin
				state_q <= nxt_state;
				peer_q  <= nxt_peer;
				our_q   <= nxt_our;
				flags_q <= nxt_flags;
			end
			if (cfg.valid) begin
				case (cfg.index)
					tnrx_pkg::CFG_ERASE: erase_q <= cfg.data;
					tnrx_pkg::CFG_KILL:  kill_q  <= cfg.data;
					tnrx_pkg::CFG_INTR:  intr_q  <= cfg.data;
					default: ;
				endcase
			end
		end
	end

endmodule

@@ rtl/tnrx_fifo.sv @@
module tnrx_fifo #(
	parameter int DEPTH = tnrx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  tnrx_pkg::item_t push_item,
	output logic            full,
	input  logic            pop,
	output logic            not_empty,
	output tnrx_pkg::item_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tnrx_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] next_ptr(input logic [PW-1:0] p);
		if (p == PW'(DEPTH - 1)) begin
			return '0;
		end
		return p + PW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (count_q < CW'(DEPTH)))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("queue read while empty");

endmodule

@@ rtl/tnrx_back.sv @@
module tnrx_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            not_empty,
	input  tnrx_pkg::item_t head,
	output logic            pop,
	tnrx_result_if.source   result
);

	logic            valid_q;
	logic [1:0]      beat_q;
	tnrx_pkg::item_t item_q;
	logic            is_last;

	assign is_last = !item_q.is_reply || (beat_q == tnrx_pkg::BEAT_OPT);
	assign pop     = not_empty && (!valid_q || (result.ready && is_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			beat_q  <= tnrx_pkg::BEAT_IAC;
		end else if (pop) begin
			valid_q <= 1'b1;
			beat_q  <= tnrx_pkg::BEAT_IAC;
		end else if (valid_q && result.ready) begin
			if (is_last) begin
				valid_q <= 1'b0;
			end else begin
				beat_q <= beat_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			item_q <= head;
		end
	end

	always_comb begin
		if (!item_q.is_reply) begin
			result.out_byte = item_q.val;
		end else begin
			case (beat_q)
				tnrx_pkg::BEAT_IAC:  result.out_byte = tnrx_pkg::B_IAC;
				tnrx_pkg::BEAT_VERB: result.out_byte = item_q.val;
				default:             result.out_byte = item_q.opt;
			endcase
		end
	end

	assign result.valid       = valid_q;
	assign result.to_network  = item_q.is_reply;
	assign result.last        = is_last;
	assign result.echo_on     = item_q.flags[tnrx_pkg::F_ECHO];
	assign result.crlf_map_on = item_q.flags[tnrx_pkg::F_CRLF];
	assign result.raw_on      = item_q.flags[tnrx_pkg::F_RAW];

	a_single_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !item_q.is_reply) |-> (beat_q == tnrx_pkg::BEAT_IAC))
		else $error("terminal byte past its first beat");

	a_beat_range: assert property (@(posedge clk) disable iff (!arst_n)
		(beat_q == tnrx_pkg::BEAT_IAC) || (beat_q == tnrx_pkg::BEAT_VERB)
		|| (beat_q == tnrx_pkg::BEAT_OPT))
		else $error("reply beat out of range");

endmodule

@@ rtl/telnet_receive_option_fsm.sv @@
// telnet receive side with option negotiation
// rx: one network byte per transaction (valid/ready). result: bytes for the
// terminal side (to_network low) or iac/verb/option replies for the network
// (to_network high); last marks the final result of one network byte, and the
// echo, crlf and raw flags give the mode after that byte.
// cfg: register writes (index 0 erase, 1 kill, 2 interrupt character), always
// ready; the user must write them only while the block is idle, which the block
// itself does not enforce. a byte is classified in the cycle it is accepted; its
// first result passes the queue and the output register to the result port. a
// data or command byte gives one result per cycle while result is ready, so bytes
// flow back to back; a negotiation reply holds the output stage until its three
// reply bytes are taken. a short queue between the classifier and output stage
// lets rx keep accepting while result stalls; rx.ready drops only when it is full.
// reset: data state, peer options clear, our options clear except echo,
// echo and crlf mapping on, raw off, registers 8, 21 and 127, queue empty.
module telnet_receive_option_fsm #(
	parameter int QUEUE_DEPTH = tnrx_pkg::QUEUE_DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tnrx_byte_if.sink     rx,
	tnrx_result_if.source result,
	tnrx_cfg_if.sink      cfg
);

	logic            push, pop, full, not_empty;
	tnrx_pkg::item_t push_item, head;

	tnrx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx),
		.cfg       (cfg),
		.full      (full),
		.push      (push),
		.push_item (push_item)
	);

	tnrx_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	tnrx_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.not_empty (not_empty),
		.head      (head),
		.pop       (pop),
		.result    (result)
	);

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	localparam int DIR_N = 37;
	localparam int LONG_HOLD = 400;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_BYTES = 106;
	localparam logic [7:0] OPT_TM = 8'd6;

	typedef enum logic [3:0] {
		RS_DATA, RS_CMD, RS_CR, RS_SUB, RS_SUBI, RS_WILL, RS_WONT, RS_DO, RS_DONT
	} rx_state_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       to_network;
		logic       last;
		logic       echo_on;
		logic       crlf_map_on;
		logic       raw_on;
	} term_result_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		logic [7:0] want;
	} dir_row_t;

	typedef struct packed {
		logic       typed;
		logic [7:0] want;
	} byte_note_t;

	logic clk = 1'b0;
	logic arst_n;

	tnrx_byte_if rx_if();
	tnrx_result_if res_if();
	tnrx_cfg_if cfg_if();

	telnet_receive_option_fsm DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx_if),
		.result (res_if),
		.cfg    (cfg_if)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	dir_row_t dir_table [DIR_N] = '{
		'{tnrx_pkg::CH_NUL, 1'b1, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_AYT, 1'b1, tnrx_pkg::CH_BEL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IP, 1'b1, tnrx_pkg::INTR_RESET},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_EC, 1'b1, tnrx_pkg::ERASE_RESET},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_EL, 1'b1, tnrx_pkg::KILL_RESET},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b1, tnrx_pkg::B_IAC},
		'{tnrx_pkg::CH_CR, 1'b1, tnrx_pkg::CH_CR},
		'{tnrx_pkg::CH_NUL, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::CH_CR, 1'b1, tnrx_pkg::CH_CR},
		'{8'h41, 1'b1, 8'h41},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_SB, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::OPT_ECHO, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_SE, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_WILL, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::OPT_ECHO, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_WILL, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::OPT_BIN, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IP, 1'b1, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_DO, 1'b0, tnrx_pkg::CH_NUL},
		'{OPT_TM, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_WONT, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::OPT_ECHO, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_IAC, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::B_DONT, 1'b0, tnrx_pkg::CH_NUL},
		'{tnrx_pkg::OPT_ECHO, 1'b0, tnrx_pkg::CH_NUL}
	};

	// predicted block state
	rx_state_t    rstate = RS_DATA;
	logic [255:0] peer_tbl = '0;
	logic [255:0] our_tbl = 256'b10;
	logic         echo_f = 1'b1;
	logic         crlf_f = 1'b1;
	logic         raw_f = 1'b0;
	logic [7:0]   erase_val = tnrx_pkg::ERASE_RESET;
	logic [7:0]   kill_val = tnrx_pkg::KILL_RESET;
	logic [7:0]   intr_val = tnrx_pkg::INTR_RESET;

	logic [7:0] pend_val [3];
	logic       pend_net [3];
	int         pend_n;

	term_result_t expected_out [$];
	byte_note_t   byte_notes [$];
	int           err_count = 0;
	int           bytes_sent = 0;
	int           calm_left = 0;
	bit           want_long_hold = 1'b0;
	bit           long_hold_done = 1'b0;

	task report_mismatch(input string what, input logic [7:0] got_v, input logic [7:0] exp_v);
		$display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got_v, exp_v);
		err_count++;
	endtask

	task emit_byte(input logic [7:0] b, input logic net);
		if (pend_n < 3) begin
			pend_val[pend_n] = b;
			pend_net[pend_n] = net;
			pend_n++;
		end
	endtask

	task emit_reply(input logic [7:0] verb, input logic [7:0] opt);
		emit_byte(tnrx_pkg::B_IAC, 1'b1);
		emit_byte(verb, 1'b1);
		emit_byte(opt, 1'b1);
	endtask

	function automatic logic is_tracked(input logic [7:0] c);
		return c == tnrx_pkg::OPT_BIN || c == tnrx_pkg::OPT_ECHO || c == tnrx_pkg::OPT_SGA;
	endfunction

	task data_in(input logic [7:0] c);
		if (c == tnrx_pkg::B_IAC) begin
			rstate = RS_CMD;
		end else begin
			emit_byte(c, 1'b0);
			if (!our_tbl[tnrx_pkg::OPT_BIN] && c == tnrx_pkg::CH_CR)
				rstate = RS_CR;
		end
	endtask

	task telnet_rx_step(input logic [7:0] c);
		pend_n = 0;
		case (rstate)
			RS_CR: begin
				rstate = RS_DATA;
				if (c != tnrx_pkg::CH_NUL && c != tnrx_pkg::CH_LF)
					data_in(c);
			end
			RS_CMD: begin
				rstate = RS_DATA;
				case (c)
					tnrx_pkg::B_IP, tnrx_pkg::B_BRK:
						emit_byte(raw_f ? tnrx_pkg::CH_NUL : intr_val, 1'b0);
					tnrx_pkg::B_AYT: emit_byte(tnrx_pkg::CH_BEL, 1'b0);
					tnrx_pkg::B_EC: emit_byte(erase_val, 1'b0);
					tnrx_pkg::B_EL: emit_byte(kill_val, 1'b0);
					tnrx_pkg::B_SB: rstate = RS_SUB;
					tnrx_pkg::B_WILL: rstate = RS_WILL;
					tnrx_pkg::B_WONT: rstate = RS_WONT;
					tnrx_pkg::B_DO: rstate = RS_DO;
					tnrx_pkg::B_DONT: rstate = RS_DONT;
					tnrx_pkg::B_IAC: emit_byte(tnrx_pkg::B_IAC, 1'b0);
					default: ;
				endcase
			end
			RS_SUB: begin
				if (c == tnrx_pkg::B_IAC)
					rstate = RS_SUBI;
			end
			RS_SUBI: rstate = (c == tnrx_pkg::B_SE) ? RS_DATA : RS_SUB;
			RS_WILL: begin
				rstate = RS_DATA;
				if (!peer_tbl[c]) begin
					if (is_tracked(c)) begin
						if (c == tnrx_pkg::OPT_BIN) begin
							raw_f = 1'b1;
						end else if (c == tnrx_pkg::OPT_ECHO) begin
							echo_f = 1'b0;
							crlf_f = 1'b0;
						end
						peer_tbl[c] = 1'b1;
						emit_reply(tnrx_pkg::B_DO, c);
					end else begin
						emit_reply(tnrx_pkg::B_DONT, c);
					end
				end
			end
			RS_WONT: begin
				rstate = RS_DATA;
				if (peer_tbl[c]) begin
					if (c == tnrx_pkg::OPT_ECHO) begin
						echo_f = 1'b1;
						crlf_f = 1'b1;
					end else if (c == tnrx_pkg::OPT_BIN) begin
						raw_f = 1'b0;
					end
					if (is_tracked(c))
						peer_tbl[c] = 1'b0;
					emit_reply(tnrx_pkg::B_DONT, c);
				end
			end
			RS_DO: begin
				rstate = RS_DATA;
				if (!our_tbl[c]) begin
					if (is_tracked(c)) begin
						if (c == tnrx_pkg::OPT_ECHO) begin
							echo_f = 1'b1;
							crlf_f = 1'b1;
						end else if (c == tnrx_pkg::OPT_BIN) begin
							raw_f = 1'b1;
						end
						our_tbl[c] = 1'b1;
						emit_reply(tnrx_pkg::B_WILL, c);
					end else begin
						emit_reply(tnrx_pkg::B_WONT, c);
					end
				end
			end
			RS_DONT: begin
				rstate = RS_DATA;
				if (our_tbl[c]) begin
					our_tbl[c] = 1'b0;
					emit_reply(tnrx_pkg::B_WONT, c);
				end
			end
			default: begin
				rstate = RS_DATA;
				data_in(c);
			end
		endcase
	endtask

	task push_pending();
		term_result_t r;
		for (int k = 0; k < pend_n; k++) begin
			r.out_byte = pend_val[k];
			r.to_network = pend_net[k];
			r.last = (k == pend_n - 1);
			r.echo_on = echo_f;
			r.crlf_map_on = crlf_f;
			r.raw_on = raw_f;
			expected_out.push_back(r);
		end
	endtask

	// prediction on accepted transactions, checking of results
	always @(posedge clk) begin
		byte_note_t   note;
		term_result_t got;
		term_result_t want;
		if (cfg_if.valid && cfg_if.ready) begin
			case (cfg_if.index)
				tnrx_pkg::CFG_ERASE: erase_val = cfg_if.data;
				tnrx_pkg::CFG_KILL: kill_val = cfg_if.data;
				tnrx_pkg::CFG_INTR: intr_val = cfg_if.data;
				default: ;
			endcase
		end
		if (rx_if.valid && rx_if.ready) begin
			note = byte_notes.pop_front();
			telnet_rx_step(rx_if.rx_byte);
			if (note.typed) begin
				if (pend_n != 1)
					report_mismatch("result count", 8'(pend_n), 8'd1);
				else
					pend_val[0] = note.want;
			end
			push_pending();
		end
		if (res_if.valid && res_if.ready) begin
			got.out_byte = res_if.out_byte;
			got.to_network = res_if.to_network;
			got.last = res_if.last;
			got.echo_on = res_if.echo_on;
			got.crlf_map_on = res_if.crlf_map_on;
			got.raw_on = res_if.raw_on;
			if (expected_out.size() == 0) begin
				report_mismatch("unexpected result", got.out_byte, 8'd0);
			end else begin
				want = expected_out.pop_front();
				if (got.out_byte !== want.out_byte)
					report_mismatch("out_byte", got.out_byte, want.out_byte);
				if (got.to_network !== want.to_network)
					report_mismatch("to_network", 8'(got.to_network),
						8'(want.to_network));
				if (got.last !== want.last)
					report_mismatch("last", 8'(got.last), 8'(want.last));
				if (got.echo_on !== want.echo_on)
					report_mismatch("echo_on", 8'(got.echo_on), 8'(want.echo_on));
				if (got.crlf_map_on !== want.crlf_map_on)
					report_mismatch("crlf_map_on", 8'(got.crlf_map_on),
						8'(want.crlf_map_on));
				if (got.raw_on !== want.raw_on)
					report_mismatch("raw_on", 8'(got.raw_on), 8'(want.raw_on));
			end
		end
	end

	// result side: random stalls, plus one long hold-off
	initial begin : result_sink
		int run;
		int gap;
		res_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (want_long_hold && !long_hold_done) begin
				res_if.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				long_hold_done = 1'b1;
			end
			res_if.ready <= 1'b1;
			run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 30);
			repeat (run) @(negedge clk);
			res_if.ready <= 1'b0;
			gap = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
			repeat (gap - 1) @(negedge clk);
		end
	end

	initial begin : watchdog
		int stalled = 0;
		while (stalled < STALL_LIMIT) begin
			@(posedge clk);
			if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
					(cfg_if.valid && cfg_if.ready))
				stalled = 0;
			else
				stalled++;
		end
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	function int sender_gap();
		int r;
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 3)
			calm_left = $urandom_range(30, 80);
		if (r < 70)
			return 0;
		if (r < 94)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// called at a falling edge, returns at the falling edge after acceptance
	task send_byte(input logic [7:0] b, input logic typed, input logic [7:0] want);
		int gap;
		byte_note_t note;
		gap = sender_gap();
		note.typed = typed;
		note.want = want;
		byte_notes.push_back(note);
		if (gap > 0) begin
			rx_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		rx_if.valid <= 1'b1;
		rx_if.rx_byte <= b;
		do @(posedge clk); while (!rx_if.ready);
		@(negedge clk);
		bytes_sent++;
	endtask

	task send_rand(input logic [7:0] b);
		send_byte(b, 1'b0, tnrx_pkg::CH_NUL);
	endtask

	task send_unit();
		int r;
		int n;
		logic [7:0] b;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			send_rand(8'($urandom_range(0, 254)));
		end else if (r < 40) begin
			send_rand(tnrx_pkg::CH_CR);
			case ($urandom_range(0, 2))
				0: send_rand(tnrx_pkg::CH_NUL);
				1: send_rand(tnrx_pkg::CH_LF);
				default: send_rand(8'($urandom_range(0, 255)));
			endcase
		end else if (r < 55) begin
			send_rand(tnrx_pkg::B_IAC);
			case ($urandom_range(0, 6))
				0: send_rand(tnrx_pkg::B_IP);
				1: send_rand(tnrx_pkg::B_BRK);
				2: send_rand(tnrx_pkg::B_AYT);
				3: send_rand(tnrx_pkg::B_EC);
				4: send_rand(tnrx_pkg::B_EL);
				5: send_rand(tnrx_pkg::B_IAC);
				default: send_rand(8'($urandom_range(0, 255)));
			endcase
		end else if (r < 85) begin
			send_rand(tnrx_pkg::B_IAC);
			case ($urandom_range(0, 3))
				0: send_rand(tnrx_pkg::B_WILL);
				1: send_rand(tnrx_pkg::B_WONT);
				2: send_rand(tnrx_pkg::B_DO);
				default: send_rand(tnrx_pkg::B_DONT);
			endcase
			n = $urandom_range(0, 99);
			if (n < 70) begin
				case ($urandom_range(0, 2))
					0: b = tnrx_pkg::OPT_BIN;
					1: b = tnrx_pkg::OPT_ECHO;
					default: b = tnrx_pkg::OPT_SGA;
				endcase
			end else if (n < 80) begin
				b = OPT_TM;
			end else begin
				b = 8'($urandom_range(0, 255));
			end
			send_rand(b);
		end else if (r < 92) begin
			send_rand(tnrx_pkg::B_IAC);
			send_rand(tnrx_pkg::B_SB);
			n = $urandom_range(0, 4);
			repeat (n) send_rand(8'($urandom_range(0, 254)));
			if ($urandom_range(0, 9) < 3) begin
				send_rand(tnrx_pkg::B_IAC);
				b = 8'($urandom_range(0, 255));
				send_rand((b == tnrx_pkg::B_SE) ? tnrx_pkg::B_SB : b);
			end
			send_rand(tnrx_pkg::B_IAC);
			send_rand(tnrx_pkg::B_SE);
		end else begin
			repeat ($urandom_range(1, 2)) send_rand(8'($urandom_range(0, 255)));
		end
	endtask

	task random_phase(input int n);
		int stop_at;
		stop_at = bytes_sent + n;
		while (bytes_sent < stop_at)
			send_unit();
	endtask

	task cfg_write(input logic [1:0] idx, input logic [7:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data <= val;
		do @(posedge clk); while (!cfg_if.ready);
		@(negedge clk);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// registers change only once every pending result is out
	task set_registers(input logic [7:0] erase_v, input logic [7:0] kill_v,
			input logic [7:0] intr_v);
		rx_if.valid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_write(tnrx_pkg::CFG_ERASE, erase_v);
		cfg_write(tnrx_pkg::CFG_KILL, kill_v);
		cfg_write(tnrx_pkg::CFG_INTR, intr_v);
	endtask

	initial begin
		arst_n = 1'b0;
		rx_if.valid = 1'b0;
		rx_if.rx_byte = 8'd0;
		cfg_if.valid = 1'b0;
		cfg_if.index = tnrx_pkg::CFG_ERASE;
		cfg_if.data = 8'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_N; i++)
			send_byte(dir_table[i].rx, dir_table[i].typed, dir_table[i].want);

		set_registers(8'h00, 8'hff, 8'h00);
		random_phase(PHASE_BYTES);
		set_registers(8'hff, 8'h00, 8'hff);
		want_long_hold = 1'b1;
		random_phase(PHASE_BYTES);
		set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		random_phase(PHASE_BYTES);
		set_registers(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
			8'($urandom_range(0, 255)));
		random_phase(PHASE_BYTES);

		rx_if.valid <= 1'b0;
		while (expected_out.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
